// ----- rtl/core/hbr_pkg.sv -----
// shared types, constants and helpers for the hid boot report block
package hbr_pkg;

    // number of keyboard key slots in a boot report
    localparam int KEY_SLOTS = 6;
    localparam int KEY_CNT_W = $clog2(KEY_SLOTS + 1);

    // usage pages and usages
    localparam logic [15:0] PAGE_GEN_DESKTOP = 16'h0001;
    localparam logic [15:0] PAGE_KEYBOARD    = 16'h0007;
    localparam logic [15:0] PAGE_BUTTON      = 16'h0009;
    localparam logic [15:0] PAGE_CONSUMER    = 16'h000C;
    localparam logic [15:0] USAGE_MOD_FIRST  = 16'h00E0;
    localparam logic [15:0] USAGE_MOD_LAST   = 16'h00E7;
    localparam logic [15:0] USAGE_X          = 16'h0030;
    localparam logic [15:0] USAGE_Y          = 16'h0031;
    localparam logic [15:0] USAGE_WHEEL      = 16'h0038;
    localparam logic [15:0] USAGE_AC_PAN     = 16'h0238;
    localparam logic [15:0] USAGE_BTN_FIRST  = 16'h0001;
    localparam logic [15:0] USAGE_BTN_LAST   = 16'h0008;

    // saturation limits
    localparam logic signed [31:0] AXIS_MAX = 32'sd127;
    localparam logic signed [31:0] AXIS_MIN = -32'sd127;

    // configuration register indexes
    localparam logic REG_KEYBOARD_ENABLE = 1'b0;
    localparam logic REG_MOUSE_ENABLE    = 1'b1;

    typedef enum logic {
        REPORT_KEYBOARD = 1'b0,
        REPORT_MOUSE    = 1'b1
    } report_kind_t;

    // one parsed report field
    typedef struct packed {
        logic [15:0]        page_code;
        logic [15:0]        usage_code;
        logic signed [31:0] field_value;
        logic               last_field;
    } in_word_t;

    // one boot report
    typedef struct packed {
        logic               report_kind;
        logic [7:0]         bits_byte;
        logic [47:0]        key_slots;
        logic signed [7:0]  move_x;
        logic signed [7:0]  move_y;
        logic signed [7:0]  scroll_wheel;
        logic signed [7:0]  scroll_pan;
        logic               last_result;
    } out_word_t;

    // collected report contents after a field is applied
    typedef struct packed {
        logic              keyboard_seen;
        logic              pointer_seen;
        logic [7:0]        modifier_bits;
        logic [47:0]       key_slots;
        logic [7:0]        button_bits;
        logic signed [7:0] axis_x;
        logic signed [7:0] axis_y;
        logic signed [7:0] axis_wheel;
        logic signed [7:0] axis_pan;
    } report_t;

    // clamp a signed value to -127..127
    function automatic logic signed [7:0] sat_axis(input logic signed [31:0] v);
        logic signed [7:0] r;
        if (v > AXIS_MAX) begin
            r = AXIS_MAX[7:0];
        end else if (v < AXIS_MIN) begin
            r = AXIS_MIN[7:0];
        end else begin
            r = v[7:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/hbr_collect.sv -----
// per-report field collector: modifier, key, button and axis state
module hbr_collect import hbr_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     accept,
    input  in_word_t word_in,
    output report_t  report_next
);

    report_t                rpt_reg;
    logic [KEY_CNT_W-1:0]   key_count_reg;
    report_t                rpt_next;
    logic [KEY_CNT_W-1:0]   key_count_next;
    logic                   nonzero;
    logic [15:0]            btn_index;

    assign nonzero   = (word_in.field_value != '0);
    assign btn_index = word_in.usage_code - USAGE_BTN_FIRST;

    // apply one field to the collected state
    always_comb begin
        rpt_next       = rpt_reg;
        key_count_next = key_count_reg;
        case (word_in.page_code)
            PAGE_KEYBOARD: begin
                rpt_next.keyboard_seen = 1'b1;
                if (nonzero) begin
                    if (word_in.usage_code >= USAGE_MOD_FIRST &&
                        word_in.usage_code <= USAGE_MOD_LAST) begin
                        rpt_next.modifier_bits[word_in.usage_code[2:0]] = 1'b1;
                    end else if (key_count_reg < KEY_CNT_W'(KEY_SLOTS)) begin
                        for (int i = 0; i < KEY_SLOTS; i++) begin
                            if (key_count_reg == KEY_CNT_W'(i)) begin
                                rpt_next.key_slots[8*i +: 8] = word_in.usage_code[7:0];
                            end
                        end
                        key_count_next = key_count_reg + 1'b1;
                    end
                end
            end
            PAGE_GEN_DESKTOP: begin
                if (word_in.usage_code == USAGE_X) begin
                    rpt_next.axis_x       = sat_axis(word_in.field_value);
                    rpt_next.pointer_seen = 1'b1;
                end else if (word_in.usage_code == USAGE_Y) begin
                    rpt_next.axis_y       = sat_axis(word_in.field_value);
                    rpt_next.pointer_seen = 1'b1;
                end else if (word_in.usage_code == USAGE_WHEEL) begin
                    rpt_next.axis_wheel   = sat_axis(word_in.field_value);
                    rpt_next.pointer_seen = 1'b1;
                end
            end
            PAGE_BUTTON: begin
                if (nonzero && word_in.usage_code >= USAGE_BTN_FIRST &&
                    word_in.usage_code <= USAGE_BTN_LAST) begin
                    rpt_next.button_bits[btn_index[2:0]] = 1'b1;
                    rpt_next.pointer_seen                = 1'b1;
                end
            end
            PAGE_CONSUMER: begin
                if (word_in.usage_code == USAGE_AC_PAN) begin
                    rpt_next.axis_pan     = sat_axis(word_in.field_value);
                    rpt_next.pointer_seen = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign report_next = rpt_next;

    // state update, cleared after the last field of a report
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rpt_reg       <= '0;
            key_count_reg <= '0;
        end else if (accept) begin
            if (word_in.last_field) begin
                rpt_reg       <= '0;
                key_count_reg <= '0;
            end else begin
                rpt_reg       <= rpt_next;
                key_count_reg <= key_count_next;
            end
        end
    end

endmodule

// ----- rtl/core/hid_fields_to_boot_reports.sv -----
// Collects parsed HID report fields (one word per cycle while s_ready is high)
// and emits keyboard and mouse boot reports. Every accepted field word is
// folded into the collector state at the accepting edge. On the field marked
// last, the finished report is copied into a pending register and the
// collector clears, so fields of the next report keep flowing. The pending
// report drains through the output register as one word (keyboard or mouse)
// or two words (keyboard then mouse); a further last field is held off only
// while a pending report still has words to send.
// Registers: keyboard_enable at 0x0, mouse_enable at 0x4.
module hid_fields_to_boot_reports import hbr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // field input
    input  logic        s_valid,
    output logic        s_ready,
    input  in_word_t    s_data,
    // report output
    output logic        m_valid,
    input  logic        m_ready,
    output out_word_t   m_data,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic      kbd_en_reg;
    logic      mouse_en_reg;
    report_t   rpt_next;
    report_t   pend_reg;
    logic      pend_kbd_reg;
    logic      pend_mouse_reg;
    logic      pend_valid;
    logic      out_load;
    logic      pend_done;
    logic      in_accept;
    logic      report_end;
    logic      emit_kbd;
    logic      emit_mouse;
    logic      m_valid_reg;
    out_word_t m_data_reg;
    out_word_t out_next;

    // configuration registers
    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kbd_en_reg   <= 1'b1;
            mouse_en_reg <= 1'b1;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_KEYBOARD_ENABLE: kbd_en_reg   <= pwdata[0];
                REG_MOUSE_ENABLE:    mouse_en_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            REG_KEYBOARD_ENABLE: prdata[0] = kbd_en_reg;
            REG_MOUSE_ENABLE:    prdata[0] = mouse_en_reg;
            default: ;
        endcase
    end

    // field collector
    hbr_collect u_collect (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (in_accept),
        .word_in     (s_data),
        .report_next (rpt_next)
    );

    // handshake and drain control
    assign pend_valid = pend_kbd_reg || pend_mouse_reg;
    assign out_load   = !m_valid_reg || m_ready;
    assign pend_done  = out_load && pend_valid && !(pend_kbd_reg && pend_mouse_reg);
    assign s_ready    = !s_data.last_field || !pend_valid || pend_done;
    assign in_accept  = s_valid && s_ready;
    assign report_end = in_accept && s_data.last_field;
    assign emit_kbd   = rpt_next.keyboard_seen && kbd_en_reg;
    assign emit_mouse = rpt_next.pointer_seen && mouse_en_reg;

    // next output word from the pending report
    always_comb begin
        out_next = '0;
        if (pend_kbd_reg) begin
            out_next.report_kind = REPORT_KEYBOARD;
            out_next.bits_byte   = pend_reg.modifier_bits;
            out_next.key_slots   = pend_reg.key_slots;
            out_next.last_result = !pend_mouse_reg;
        end else begin
            out_next.report_kind  = REPORT_MOUSE;
            out_next.bits_byte    = pend_reg.button_bits;
            out_next.move_x       = pend_reg.axis_x;
            out_next.move_y       = pend_reg.axis_y;
            out_next.scroll_wheel = pend_reg.axis_wheel;
            out_next.scroll_pan   = pend_reg.axis_pan;
            out_next.last_result  = 1'b1;
        end
    end

    // pending report flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_kbd_reg   <= 1'b0;
            pend_mouse_reg <= 1'b0;
        end else if (report_end) begin
            pend_kbd_reg   <= emit_kbd;
            pend_mouse_reg <= emit_mouse;
        end else if (out_load && pend_valid) begin
            if (pend_kbd_reg) begin
                pend_kbd_reg <= 1'b0;
            end else begin
                pend_mouse_reg <= 1'b0;
            end
        end
    end

    // pending report contents
    always_ff @(posedge aclk) begin
        if (report_end) begin
            pend_reg <= rpt_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= pend_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load && pend_valid) begin
            m_data_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
